// File: rtl/core/ledd_pkg.sv
package ledd_pkg;

    localparam int PIXEL_DEPTH = 64;
    localparam int PIX_AW      = $clog2(PIXEL_DEPTH);
    localparam int PIX_CW      = PIX_AW + 1;
    localparam int WORD_W      = 24;
    localparam int BIT_CW      = 5;
    localparam int CNT_W       = 16;
    localparam int CFG_AW      = 2;
    localparam int CFG_DW      = 16;

    localparam logic [BIT_CW-1:0] LAST_BIT = BIT_CW'(WORD_W - 1);

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_SET     = 3'd1;
    localparam logic [2:0] CMD_FILL    = 3'd2;
    localparam logic [2:0] CMD_READ    = 3'd3;
    localparam logic [2:0] CMD_REFRESH = 3'd4;

    localparam logic [CFG_AW-1:0] CFG_LED_COUNT   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SHORT_TICKS = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_LONG_TICKS  = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_GAP_TICKS   = 2'd3;

    localparam logic [6:0]  RST_LED_COUNT   = 7'd60;
    localparam logic [7:0]  RST_SHORT_TICKS = 8'd10;
    localparam logic [7:0]  RST_LONG_TICKS  = 8'd20;
    localparam logic [15:0] RST_GAP_TICKS   = 16'd2000;

    typedef struct packed {
        logic [2:0] command;
        logic [5:0] start_position;
        logic [6:0] end_position;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic       line_level;
        logic       busy_res;
        logic       frame_done;
        logic       rejected;
        logic [7:0] read_red;
        logic [7:0] read_green;
        logic [7:0] read_blue;
    } t_out_item;

    typedef struct packed {
        logic              tick;
        logic              start;
        logic              load;
        logic [WORD_W-1:0] word;
    } t_wave_ctl;

    typedef struct packed {
        logic              sending;
        logic              in_gap;
        logic              high_phase;
        logic              tick_done;
        logic              tick_load;
        logic [PIX_AW-1:0] pixel_index;
    } t_wave_sts;

endpackage

// File: rtl/core/ledd_ram.sv
module ledd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/ledd_wave.sv
module ledd_wave (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ledd_pkg::t_wave_ctl        i_ctl,
    input  logic [ledd_pkg::PIX_CW-1:0] i_frame_len,
    input  logic [7:0]                 i_short_ticks,
    input  logic [7:0]                 i_long_ticks,
    input  logic [15:0]                i_gap_ticks,
    output ledd_pkg::t_wave_sts        o_sts
);

    logic                          r_sending, n_sending;
    logic                          r_in_gap, n_in_gap;
    logic                          r_high, n_high;
    logic [ledd_pkg::PIX_AW-1:0]   r_pix, n_pix;
    logic [ledd_pkg::BIT_CW-1:0]   r_bit, n_bit;
    logic [ledd_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [ledd_pkg::WORD_W-1:0]   r_word, n_word;
    logic [ledd_pkg::CNT_W-1:0]    w_cnt_dec;
    logic                          w_tick_done;
    logic                          w_tick_load;

    // A phase lasts long_ticks when its level matches the data bit, else short_ticks.
    function automatic logic [ledd_pkg::CNT_W-1:0] f_phase(
        input logic       high,
        input logic       bit_v,
        input logic [7:0] s_ticks,
        input logic [7:0] l_ticks
    );
        logic [7:0] t;
        t = (high == bit_v) ? l_ticks : s_ticks;
        if (t == 8'd0) begin
            t = 8'd1;
        end
        return ledd_pkg::CNT_W'(t);
    endfunction

    assign w_cnt_dec = r_cnt - ledd_pkg::CNT_W'(1);

    always_comb begin
        n_sending   = r_sending;
        n_in_gap    = r_in_gap;
        n_high      = r_high;
        n_pix       = r_pix;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_word      = r_word;
        w_tick_done = 1'b0;
        w_tick_load = 1'b0;
        if (i_ctl.start) begin
            n_pix = '0;
            n_bit = '0;
            if (i_frame_len == '0) begin
                n_sending = 1'b0;
                n_high    = 1'b0;
                n_in_gap  = (i_gap_ticks != 16'd0);
                n_cnt     = i_gap_ticks;
            end else begin
                n_sending = 1'b1;
                n_high    = 1'b1;
                n_in_gap  = 1'b0;
            end
        end else if (i_ctl.load) begin
            n_word    = i_ctl.word;
            n_bit     = '0;
            n_sending = 1'b1;
            n_high    = 1'b1;
            n_cnt     = f_phase(1'b1, i_ctl.word[ledd_pkg::WORD_W-1],
                                i_short_ticks, i_long_ticks);
        end else if (i_ctl.tick) begin
            if (r_sending) begin
                n_cnt = w_cnt_dec;
                if (w_cnt_dec == '0) begin
                    if (r_high) begin
                        n_high = 1'b0;
                        n_cnt  = f_phase(1'b0, r_word[ledd_pkg::WORD_W-1],
                                         i_short_ticks, i_long_ticks);
                    end else begin
                        n_word = {r_word[ledd_pkg::WORD_W-2:0], 1'b0};
                        if (r_bit == ledd_pkg::LAST_BIT) begin
                            n_bit = '0;
                            n_pix = r_pix + ledd_pkg::PIX_AW'(1);
                            if ((ledd_pkg::PIX_CW'(r_pix) + ledd_pkg::PIX_CW'(1))
                                    >= i_frame_len) begin
                                n_sending = 1'b0;
                                n_high    = 1'b0;
                                n_in_gap  = (i_gap_ticks != 16'd0);
                                n_cnt     = i_gap_ticks;
                                w_tick_done = (i_gap_ticks == 16'd0);
                            end else begin
                                // The next pixel comes from the store before the next tick.
                                w_tick_load = 1'b1;
                            end
                        end else begin
                            n_bit  = r_bit + ledd_pkg::BIT_CW'(1);
                            n_high = 1'b1;
                            n_cnt  = f_phase(1'b1, r_word[ledd_pkg::WORD_W-2],
                                             i_short_ticks, i_long_ticks);
                        end
                    end
                end
            end else if (r_in_gap) begin
                n_cnt = w_cnt_dec;
                if (w_cnt_dec == '0) begin
                    n_in_gap    = 1'b0;
                    w_tick_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending <= 1'b0;
            r_in_gap  <= 1'b0;
            r_high    <= 1'b0;
            r_pix     <= '0;
            r_bit     <= '0;
            r_cnt     <= '0;
            r_word    <= '0;
        end else begin
            r_sending <= n_sending;
            r_in_gap  <= n_in_gap;
            r_high    <= n_high;
            r_pix     <= n_pix;
            r_bit     <= n_bit;
            r_cnt     <= n_cnt;
            r_word    <= n_word;
        end
    end

    assign o_sts.sending     = r_sending;
    assign o_sts.in_gap      = r_in_gap;
    assign o_sts.high_phase  = r_high;
    assign o_sts.tick_done   = w_tick_done;
    assign o_sts.tick_load   = w_tick_load;
    assign o_sts.pixel_index = r_pix;

`ifndef SYNTHESIS
    a_sending_gap_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_sending && r_in_gap))
        else $error("frame and gap both active");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sending |-> (r_bit <= ledd_pkg::LAST_BIT))
        else $error("bit index past the end of a pixel");

    a_gap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_gap |-> (r_cnt != '0))
        else $error("gap running with no ticks left");
`endif

endmodule

// File: rtl/core/addressable_led_strip_driver_top.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | i_in_valid / o_in_stall   | i_in_item  (ledd_pkg::t_in_item)
// out     | output    | o_out_valid / i_out_stall | o_out_item (ledd_pkg::t_out_item)
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Pixel data leaves a shift register MSB first, each bit sent as a high phase then a low phase.
// At each pixel boundary, and after set, fill or refresh that starts a frame, the
// input stalls in the load states while the next pixel is read from the store's single read port.
// Fill also stalls while its sweep paints each pixel (end - start, at most 64); read stalls in S_READ.
// Reset is synchronous and clears the store at once through per-pixel valid bits.
// A result waits in the output register; while it is stalled there, no new item is accepted.
module addressable_led_strip_driver_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ledd_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ledd_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ledd_pkg::CFG_AW-1:0]   i_cfg_index,
    input  logic [ledd_pkg::CFG_DW-1:0]   i_cfg_data
);

    typedef enum logic [4:0] {
        S_RUN       = 5'b00001,
        S_FILL      = 5'b00010,
        S_LOAD_ADDR = 5'b00100,
        S_LOAD_DATA = 5'b01000,
        S_READ      = 5'b10000
    } t_state;

    t_state                        r_state, n_state;
    logic [6:0]                    r_led_count;
    logic [7:0]                    r_short_ticks;
    logic [7:0]                    r_long_ticks;
    logic [15:0]                   r_gap_ticks;
    logic                          r_out_valid;
    ledd_pkg::t_out_item           r_out;
    logic [ledd_pkg::PIXEL_DEPTH-1:0] r_valid, n_valid;
    logic [ledd_pkg::PIX_AW-1:0]   r_fill_idx, n_fill_idx;
    logic [ledd_pkg::PIX_CW-1:0]   r_fill_end, n_fill_end;
    logic [ledd_pkg::WORD_W-1:0]   r_colour, n_colour;
    logic                          r_rd_vld;

    logic [ledd_pkg::PIX_CW-1:0]   w_frame_len;
    logic [ledd_pkg::PIX_CW-1:0]   w_end_clip;
    logic [ledd_pkg::WORD_W-1:0]   w_colour;
    logic [ledd_pkg::WORD_W-1:0]   w_rdata;
    logic [ledd_pkg::WORD_W-1:0]   w_rd_word;
    logic                          w_busy;
    logic                          w_can_take;
    logic                          w_acc;
    logic                          w_pos_ok;
    logic                          w_start;
    logic                          w_out_load;
    logic                          w_we;
    logic [ledd_pkg::PIX_AW-1:0]   w_waddr;
    logic [ledd_pkg::WORD_W-1:0]   w_wdata;
    logic [ledd_pkg::PIX_AW-1:0]   w_raddr;
    logic                          w_clear_lo;
    ledd_pkg::t_out_item           w_res;
    ledd_pkg::t_wave_ctl           w_ctl;
    ledd_pkg::t_wave_sts           w_sts;

    assign w_frame_len = (32'(r_led_count) > ledd_pkg::PIXEL_DEPTH)
                       ? ledd_pkg::PIX_CW'(ledd_pkg::PIXEL_DEPTH)
                       : ledd_pkg::PIX_CW'(r_led_count);
    assign w_end_clip  = (32'(i_in_item.end_position) > ledd_pkg::PIXEL_DEPTH)
                       ? ledd_pkg::PIX_CW'(ledd_pkg::PIXEL_DEPTH)
                       : ledd_pkg::PIX_CW'(i_in_item.end_position);
    assign w_colour    = {i_in_item.green, i_in_item.red, i_in_item.blue};
    assign w_pos_ok    = (32'(i_in_item.start_position) < ledd_pkg::PIXEL_DEPTH);
    assign w_busy      = w_sts.sending | w_sts.in_gap;
    assign w_can_take  = (r_state == S_RUN) && (!r_out_valid || !i_out_stall);
    assign w_acc       = i_in_valid && w_can_take;
    assign w_rd_word   = r_rd_vld ? w_rdata : '0;

    always_comb begin
        n_state          = r_state;
        n_fill_idx       = r_fill_idx;
        n_fill_end       = r_fill_end;
        n_colour         = r_colour;
        w_start          = 1'b0;
        w_out_load       = 1'b0;
        w_we             = 1'b0;
        w_waddr          = ledd_pkg::PIX_AW'(i_in_item.start_position);
        w_wdata          = w_colour;
        w_raddr          = w_sts.pixel_index;
        w_clear_lo       = 1'b0;
        w_ctl            = '0;
        w_res            = '0;
        w_res.line_level = w_sts.sending & w_sts.high_phase;
        w_res.busy_res   = w_busy;
        case (r_state)
            S_RUN: begin
                if (w_acc) begin
                    w_out_load = 1'b1;
                    if (i_in_item.command == ledd_pkg::CMD_TICK) begin
                        w_ctl.tick       = 1'b1;
                        w_res.frame_done = w_sts.tick_done;
                        if (w_sts.tick_load) begin
                            n_state = S_LOAD_ADDR;
                        end
                    end else if (w_busy || (i_in_item.command > ledd_pkg::CMD_REFRESH)) begin
                        w_res.rejected = 1'b1;
                    end else begin
                        case (i_in_item.command)
                            ledd_pkg::CMD_SET: begin
                                if (!w_pos_ok) begin
                                    w_res.rejected = 1'b1;
                                end else begin
                                    w_we    = 1'b1;
                                    w_start = 1'b1;
                                end
                            end
                            ledd_pkg::CMD_FILL: begin
                                w_clear_lo = 1'b1;
                                w_start    = 1'b1;
                                n_fill_idx = ledd_pkg::PIX_AW'(i_in_item.start_position);
                                n_fill_end = w_end_clip;
                                n_colour   = w_colour;
                            end
                            ledd_pkg::CMD_READ: begin
                                if (!w_pos_ok) begin
                                    w_res.rejected = 1'b1;
                                end else begin
                                    w_raddr    = ledd_pkg::PIX_AW'(i_in_item.start_position);
                                    w_out_load = 1'b0;
                                    n_state    = S_READ;
                                end
                            end
                            ledd_pkg::CMD_REFRESH: begin
                                w_start = 1'b1;
                            end
                            default: begin
                                w_res.rejected = 1'b1;
                            end
                        endcase
                        if (w_start) begin
                            w_ctl.start      = 1'b1;
                            w_res.line_level = (w_frame_len != '0);
                            w_res.busy_res   = (w_frame_len != '0) || (r_gap_ticks != 16'd0);
                            w_res.frame_done = (w_frame_len == '0) && (r_gap_ticks == 16'd0);
                            if ((i_in_item.command == ledd_pkg::CMD_FILL) &&
                                (ledd_pkg::PIX_CW'(i_in_item.start_position) < w_end_clip)) begin
                                n_state = S_FILL;
                            end else if (w_frame_len != '0) begin
                                n_state = S_LOAD_ADDR;
                            end
                        end
                    end
                end
            end
            S_FILL: begin
                w_we       = 1'b1;
                w_waddr    = r_fill_idx;
                w_wdata    = r_colour;
                n_fill_idx = r_fill_idx + ledd_pkg::PIX_AW'(1);
                if ((ledd_pkg::PIX_CW'(r_fill_idx) + ledd_pkg::PIX_CW'(1)) >= r_fill_end) begin
                    n_state = (w_frame_len != '0) ? S_LOAD_ADDR : S_RUN;
                end
            end
            S_LOAD_ADDR: begin
                n_state = S_LOAD_DATA;
            end
            S_LOAD_DATA: begin
                w_ctl.load = 1'b1;
                w_ctl.word = w_rd_word;
                n_state    = S_RUN;
            end
            S_READ: begin
                w_out_load       = 1'b1;
                w_res.read_green = w_rd_word[23:16];
                w_res.read_red   = w_rd_word[15:8];
                w_res.read_blue  = w_rd_word[7:0];
                n_state          = S_RUN;
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // A fill drops the pixels it clears by their valid bits; the sweep then paints its range.
    always_comb begin
        n_valid = r_valid;
        for (int i = 0; i < ledd_pkg::PIXEL_DEPTH; i++) begin
            if (w_clear_lo && (ledd_pkg::PIX_CW'(i) < w_frame_len)) begin
                n_valid[i] = 1'b0;
            end
        end
        if (w_we) begin
            n_valid[w_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_RUN;
            r_led_count   <= ledd_pkg::RST_LED_COUNT;
            r_short_ticks <= ledd_pkg::RST_SHORT_TICKS;
            r_long_ticks  <= ledd_pkg::RST_LONG_TICKS;
            r_gap_ticks   <= ledd_pkg::RST_GAP_TICKS;
            r_out_valid   <= 1'b0;
            r_valid       <= '0;
            r_rd_vld      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_rd_vld <= r_valid[w_raddr];
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ledd_pkg::CFG_LED_COUNT:   r_led_count   <= i_cfg_data[6:0];
                    ledd_pkg::CFG_SHORT_TICKS: r_short_ticks <= i_cfg_data[7:0];
                    ledd_pkg::CFG_LONG_TICKS:  r_long_ticks  <= i_cfg_data[7:0];
                    ledd_pkg::CFG_GAP_TICKS:   r_gap_ticks   <= i_cfg_data[15:0];
                    default: begin
                        r_gap_ticks <= r_gap_ticks;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_res;
        end
        r_fill_idx <= n_fill_idx;
        r_fill_end <= n_fill_end;
        r_colour   <= n_colour;
    end

    ledd_ram #(
        .WIDTH (ledd_pkg::WORD_W),
        .DEPTH (ledd_pkg::PIXEL_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ledd_wave u_wave (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_frame_len   (w_frame_len),
        .i_short_ticks (r_short_ticks),
        .i_long_ticks  (r_long_ticks),
        .i_gap_ticks   (r_gap_ticks),
        .o_sts         (w_sts)
    );

    assign o_in_stall  = !w_can_take;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_load_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD_DATA) |=> (r_state == S_RUN))
        else $error("pixel load did not return to run");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (ledd_pkg::PIX_CW'(r_fill_idx) < r_fill_end))
        else $error("fill sweep beyond its end");

    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> r_out_valid)
        else $error("read item produced no result");
`endif

endmodule

// File: tb/tb.sv
module tb;
    import ledd_pkg::*;

    localparam logic [2:0] CMD_CODE_MAX = 3'd7;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              in_valid  = 1'b0;
    t_in_item          in_item   = '0;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CFG_AW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_cfg_ready;
    t_out_item         o_out_item;

    addressable_led_strip_driver_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Strip model: pixel store, register copies and waveform position.
    logic [WORD_W-1:0] pix_mem [0:PIXEL_DEPTH-1];
    logic [6:0]        cfg_leds  = RST_LED_COUNT;
    logic [7:0]        cfg_short = RST_SHORT_TICKS;
    logic [7:0]        cfg_long  = RST_LONG_TICKS;
    logic [15:0]       cfg_gap   = RST_GAP_TICKS;
    logic              m_sending = 1'b0;
    logic              m_gap     = 1'b0;
    logic              m_high    = 1'b0;
    int                m_pix     = 0;
    int                m_bit     = 0;
    int                m_left    = 0;
    logic [WORD_W-1:0] m_word    = '0;

    t_in_item  pending_cmds[$];
    t_out_item expected_line_states[$];
    t_out_item want;
    int        err_count        = 0;
    int        frame_ticks_left = 0;
    int        burst_left       = 0;
    int        send_pause       = 0;
    int        run_left         = 0;
    int        stall_left       = 0;
    int        phase_no;
    int        k;

    function automatic int frame_pixels();
        return (cfg_leds > PIXEL_DEPTH) ? PIXEL_DEPTH : int'(cfg_leds);
    endfunction

    // A 1 bit is long high then short low; a 0 bit is the reverse.
    function automatic int phase_ticks(input logic high);
        logic [7:0] t;
        t = (high == m_word[WORD_W-1]) ? cfg_long : cfg_short;
        return (t == 8'd0) ? 1 : int'(t);
    endfunction

    function automatic logic enter_gap();
        m_sending = 1'b0;
        m_high    = 1'b0;
        if (cfg_gap == 16'd0) begin
            m_gap  = 1'b0;
            m_left = 0;
            return 1'b1;
        end
        m_gap  = 1'b1;
        m_left = int'(cfg_gap);
        return 1'b0;
    endfunction

    function automatic void load_pixel();
        m_word    = pix_mem[m_pix];
        m_bit     = 0;
        m_sending = 1'b1;
        m_high    = 1'b1;
        m_left    = phase_ticks(1'b1);
    endfunction

    function automatic logic start_frame();
        m_pix = 0;
        m_bit = 0;
        if (frame_pixels() == 0) begin
            return enter_gap();
        end
        load_pixel();
        return 1'b0;
    endfunction

    function automatic t_out_item strip_step(input t_in_item it);
        t_out_item         r;
        logic [WORD_W-1:0] colour;
        logic [WORD_W-1:0] rd;
        int                i;
        int                e;
        r      = '0;
        rd     = '0;
        colour = {it.green, it.red, it.blue};
        if (it.command == CMD_TICK) begin
            if (m_sending) begin
                r.line_level = m_high;
                r.busy_res   = 1'b1;
                m_left--;
                if (m_left == 0) begin
                    if (m_high) begin
                        m_high = 1'b0;
                        m_left = phase_ticks(1'b0);
                    end else begin
                        m_word = m_word << 1;
                        m_bit++;
                        if (m_bit >= WORD_W) begin
                            m_bit = 0;
                            m_pix++;
                            if (m_pix >= frame_pixels()) begin
                                r.frame_done = enter_gap();
                            end else begin
                                load_pixel();
                            end
                        end else begin
                            m_high = 1'b1;
                            m_left = phase_ticks(1'b1);
                        end
                    end
                end
            end else if (m_gap) begin
                r.busy_res = 1'b1;
                m_left--;
                if (m_left == 0) begin
                    m_gap        = 1'b0;
                    r.frame_done = 1'b1;
                end
            end
        end else begin
            if (m_sending || m_gap || it.command > CMD_REFRESH) begin
                r.rejected = 1'b1;
            end else begin
                case (it.command)
                    CMD_SET: begin
                        if (int'(it.start_position) >= PIXEL_DEPTH) begin
                            r.rejected = 1'b1;
                        end else begin
                            pix_mem[it.start_position] = colour;
                            r.frame_done = start_frame();
                        end
                    end
                    CMD_FILL: begin
                        e = (it.end_position > PIXEL_DEPTH) ? PIXEL_DEPTH
                                                            : int'(it.end_position);
                        for (i = 0; i < frame_pixels(); i++) pix_mem[i] = '0;
                        for (i = int'(it.start_position); i < e; i++) pix_mem[i] = colour;
                        r.frame_done = start_frame();
                    end
                    CMD_READ: begin
                        if (int'(it.start_position) >= PIXEL_DEPTH) begin
                            r.rejected = 1'b1;
                        end else begin
                            rd = pix_mem[it.start_position];
                        end
                    end
                    CMD_REFRESH: begin
                        r.frame_done = start_frame();
                    end
                    default: ;
                endcase
            end
            r.busy_res   = m_sending || m_gap;
            r.line_level = m_sending && m_high;
        end
        r.read_red   = rd[15:8];
        r.read_green = rd[23:16];
        r.read_blue  = rd[7:0];
        return r;
    endfunction

    // Ticks from a frame start until the strip is idle again.
    function automatic int frame_duration();
        int s;
        int l;
        s = (cfg_short == 8'd0) ? 1 : int'(cfg_short);
        l = (cfg_long == 8'd0) ? 1 : int'(cfg_long);
        return frame_pixels() * WORD_W * (s + l) + int'(cfg_gap);
    endfunction

    function automatic t_in_item rand_item(input logic [2:0] cmd);
        t_in_item it;
        it.command        = cmd;
        it.start_position = 6'($urandom);
        it.end_position   = ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                                        : 7'($urandom_range(0, PIXEL_DEPTH));
        it.red            = 8'($urandom);
        it.green          = 8'($urandom);
        it.blue           = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item mk(input logic [2:0] cmd, input logic [5:0] st,
                                    input logic [6:0] en, input logic [23:0] rgb);
        t_in_item it;
        it = rand_item(cmd);
        it.start_position = st;
        it.end_position   = en;
        it.red            = rgb[23:16];
        it.green          = rgb[15:8];
        it.blue           = rgb[7:0];
        return it;
    endfunction

    // The stimulus keeps a rough count of ticks left in the current frame so
    // that most commands land while the strip is idle.
    task automatic queue_item(input t_in_item it);
        pending_cmds.push_back(it);
        if (it.command == CMD_TICK) begin
            if (frame_ticks_left > 0) frame_ticks_left--;
        end else if (frame_ticks_left == 0 && (it.command == CMD_SET ||
                     it.command == CMD_FILL || it.command == CMD_REFRESH)) begin
            frame_ticks_left = frame_duration();
        end
    endtask

    task automatic finish_frame();
        while (frame_ticks_left > 0) queue_item(rand_item(CMD_TICK));
    endtask

    task automatic queue_random();
        int pick;
        pick = $urandom_range(0, 19);
        if (frame_ticks_left > 0) begin
            if (pick < 2) begin
                queue_item(rand_item(3'($urandom_range(CMD_SET, CMD_CODE_MAX))));
            end else begin
                queue_item(rand_item(CMD_TICK));
            end
        end else if (pick < 6) begin
            queue_item(rand_item(CMD_READ));
        end else if (pick < 8) begin
            queue_item(rand_item(CMD_TICK));
        end else if (pick < 9) begin
            queue_item(rand_item(3'($urandom_range(CMD_REFRESH + 1, CMD_CODE_MAX))));
        end else if (pick < 13) begin
            queue_item(rand_item(CMD_SET));
        end else if (pick < 17) begin
            queue_item(rand_item(CMD_FILL));
        end else begin
            queue_item(rand_item(CMD_REFRESH));
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_cmds.size() != 0 || in_valid || expected_line_states.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LED_COUNT:   cfg_leds  = val[6:0];
            CFG_SHORT_TICKS: cfg_short = val[7:0];
            CFG_LONG_TICKS:  cfg_long  = val[7:0];
            CFG_GAP_TICKS:   cfg_gap   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [6:0] leds, input logic [7:0] s,
                              input logic [7:0] l, input logic [15:0] gap);
        finish_frame();
        wait_drained();
        write_reg(CFG_LED_COUNT, CFG_DW'(leds));
        write_reg(CFG_SHORT_TICKS, CFG_DW'(s));
        write_reg(CFG_LONG_TICKS, CFG_DW'(l));
        write_reg(CFG_GAP_TICKS, gap);
    endtask

    // Command driver: bursts of items separated by random pauses.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_line_states.push_back(strip_step(in_item));
            end
            if (!in_valid || !o_in_stall) begin
                if (send_pause > 0) begin
                    send_pause--;
                    in_valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    in_item  <= pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        send_pause = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with its own stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_line_states.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) $display("unexpected line state %h", o_out_item);
                end else begin
                    want = expected_line_states.pop_front();
                    if (o_out_item !== want) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("line state mismatch: exp lvl %b busy %b done %b rej %b",
                                     want.line_level, want.busy_res, want.frame_done,
                                     want.rejected, " rgb %h %h %h", want.read_red,
                                     want.read_green, want.read_blue);
                            $display("                     got lvl %b busy %b done %b rej %b",
                                     o_out_item.line_level, o_out_item.busy_res,
                                     o_out_item.frame_done, o_out_item.rejected,
                                     " rgb %h %h %h", o_out_item.read_red,
                                     o_out_item.read_green, o_out_item.read_blue);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (run_left > 0) begin
                run_left--;
                out_stall <= 1'b0;
            end else begin
                run_left   = $urandom_range(0, 24);
                stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        for (k = 0; k < PIXEL_DEPTH; k++) pix_mem[k] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: cleared store, idle tick, unknown codes, then a
        // default frame with commands thrown at it while it runs.
        queue_item(mk(CMD_READ, 6'd0, 7'd0, 24'h0));
        queue_item(mk(CMD_READ, 6'd63, 7'd0, 24'h0));
        queue_item(mk(CMD_TICK, 6'd63, 7'd127, 24'hffffff));
        queue_item(mk(CMD_CODE_MAX, 6'd0, 7'd0, 24'h0));
        queue_item(mk(3'(CMD_REFRESH + 1), 6'd1, 7'd2, 24'h123456));
        queue_item(mk(CMD_SET, 6'd63, 7'd0, 24'hffffff));
        queue_item(mk(CMD_READ, 6'd63, 7'd0, 24'h0));
        queue_item(mk(CMD_SET, 6'd1, 7'd0, 24'h010203));
        queue_item(mk(CMD_FILL, 6'd0, 7'd64, 24'h0a0b0c));
        queue_item(mk(CMD_REFRESH, 6'd0, 7'd0, 24'h0));
        queue_item(mk(3'(CMD_REFRESH + 2), 6'd0, 7'd0, 24'h0));
        finish_frame();
        queue_item(mk(CMD_READ, 6'd63, 7'd0, 24'h0));

        // Full store, fastest bits, no gap: the last bit ends the frame.
        set_timing(7'd64, 8'd1, 8'd1, 16'd0);
        queue_item(mk(CMD_FILL, 6'd0, 7'd64, 24'ha55ac3));
        finish_frame();
        queue_item(mk(CMD_READ, 6'd17, 7'd0, 24'h0));
        // Empty paint range still clears and sends.
        queue_item(mk(CMD_FILL, 6'd10, 7'd3, 24'hffffff));
        finish_frame();
        queue_item(mk(CMD_READ, 6'd10, 7'd0, 24'h0));

        // Pixel count beyond the store and a clipped fill end.
        set_timing(7'd100, 8'd1, 8'd1, 16'd1);
        queue_item(mk(CMD_FILL, 6'd60, 7'd127, 24'h00ff00));
        finish_frame();
        queue_item(mk(CMD_READ, 6'd63, 7'd0, 24'h0));

        // Empty frame with no gap ends on the starting command itself.
        set_timing(7'd0, 8'd1, 8'd1, 16'd0);
        queue_item(mk(CMD_REFRESH, 6'd0, 7'd0, 24'h0));
        queue_item(mk(CMD_SET, 6'd5, 7'd0, 24'h800001));

        // Zero phase lengths act as a single tick.
        set_timing(7'd1, 8'd0, 8'd0, 16'd3);
        queue_item(mk(CMD_SET, 6'd0, 7'd0, 24'h800001));

        // Slowest phases and the longest gap.
        set_timing(7'd1, 8'd255, 8'd255, 16'hffff);
        queue_item(mk(CMD_REFRESH, 6'd0, 7'd0, 24'h0));

        for (phase_no = 0; phase_no < 6; phase_no++) begin
            set_timing(7'($urandom_range(0, 3)), 8'($urandom_range(1, 3)),
                       8'($urandom_range(1, 3)), 16'($urandom_range(0, 6)));
            repeat (75) queue_random();
        end
        finish_frame();
        wait_drained();
        repeat (20) @(posedge i_clk);
        err_count += expected_line_states.size();
        if (err_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
